>>> rtl/core/tmsacc_pkg.sv
`timescale 1ns / 1ps

package tmsacc_pkg;

   // Field widths
   localparam int TICK_W = 32;
   localparam int TPM_W  = 31;
   localparam int MS_W   = 32;
   localparam int CNT_W  = $clog2(TICK_W);

   // Divisor after reset
   localparam logic [TPM_W-1:0] TPM_RESET = TPM_W'(1000);

   // Last divide step index
   localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(TICK_W - 1);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIVIDE,
      ST_ACCUM,
      ST_WRAP,
      ST_PUBLISH
   } state_type;

   // Controller to datapath commands
   typedef struct packed {
      logic load;
      logic step;
      logic accum;
      logic wrap;
      logic publish;
   } cmd_type;

   // Datapath to controller status
   typedef struct packed {
      logic div_zero;
      logic div_last;
      logic out_busy;
   } status_type;

endpackage

>>> rtl/core/tick_to_ms_accumulator_core.sv
`timescale 1ns / 1ps

// Tick to millisecond accumulator.
// req_ beats carry the timer ticks elapsed since the previous beat. Each is
// divided by the ticks-per-millisecond register; the quotient is added to a
// running millisecond count (wraps at 2^32) and the remainder to a kept tick
// residue, which folds one divisor back into a millisecond when it reaches it.
// Every req_ beat yields one rsp_ beat with the updated count and residue.
// A zero divisor leaves both counts untouched and reports them as they stand.
// csr_ writes the 31-bit divisor; it is always ready. The user must ensure it is
// written only while the block is idle; the block does not enforce this.
// From req_ accept to rsp_valid an item passes 32 divide steps at one
// quotient bit per cycle, then accumulate, fold and publish; with a zero
// divisor it goes from the accept straight to publish. One item is in flight
// at a time and the accept takes an idle cycle of its own, so a new req_ beat
// is taken only once the last item has been published.
// The result sits in an output register: a new req_ beat is taken while it
// waits, and a stalled receiver only holds the next item at its publish step.
// Reset clears both counts, the output valid and loads a divisor of 1000.
module tick_to_ms_accumulator_core (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [tmsacc_pkg::TPM_W-1:0]  csr_ticks_per_milli,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [tmsacc_pkg::TICK_W-1:0] req_elapsed_ticks,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [tmsacc_pkg::MS_W-1:0]   rsp_millis_now,
   output logic [tmsacc_pkg::MS_W-1:0]   rsp_leftover_ticks
);
   import tmsacc_pkg::*;

   cmd_type    cmd;
   status_type status;

   tmsacc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   tmsacc_dpath u_dpath (
      .clock               (clock),
      .reset               (reset),
      .csr_valid           (csr_valid),
      .csr_ready           (csr_ready),
      .csr_ticks_per_milli (csr_ticks_per_milli),
      .req_elapsed_ticks   (req_elapsed_ticks),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_millis_now      (rsp_millis_now),
      .rsp_leftover_ticks  (rsp_leftover_ticks),
      .cmd                 (cmd),
      .status              (status)
   );

endmodule

>>> rtl/core/tmsacc_ctrl.sv
`timescale 1ns / 1ps

module tmsacc_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  tmsacc_pkg::status_type status,
   output tmsacc_pkg::cmd_type    cmd
);
   import tmsacc_pkg::*;

   state_type state_ff;
   state_type state_in;
   logic      accept;

   assign accept = req_valid && (state_ff == ST_IDLE);

   // Hold the state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Advance through divide, accumulate, wrap and publish; a zero divisor skips to publish
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = status.div_zero ? ST_PUBLISH : ST_DIVIDE;
            end
         end
         ST_DIVIDE: begin
            if (status.div_last) begin
               state_in = ST_ACCUM;
            end
         end
         ST_ACCUM: begin
            state_in = ST_WRAP;
         end
         ST_WRAP: begin
            state_in = ST_PUBLISH;
         end
         ST_PUBLISH: begin
            if (!status.out_busy) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Drive commands from the current state
   always_comb begin
      req_ready   = 1'b0;
      cmd         = '0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            cmd.load  = accept;
         end
         ST_DIVIDE: begin
            cmd.step = 1'b1;
         end
         ST_ACCUM: begin
            cmd.accum = 1'b1;
         end
         ST_WRAP: begin
            cmd.wrap = 1'b1;
         end
         ST_PUBLISH: begin
            cmd.publish = !status.out_busy;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

endmodule

>>> rtl/core/tmsacc_dpath.sv
`timescale 1ns / 1ps

module tmsacc_dpath (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [tmsacc_pkg::TPM_W-1:0]  csr_ticks_per_milli,
   input  logic [tmsacc_pkg::TICK_W-1:0] req_elapsed_ticks,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [tmsacc_pkg::MS_W-1:0]   rsp_millis_now,
   output logic [tmsacc_pkg::MS_W-1:0]   rsp_leftover_ticks,
   input  tmsacc_pkg::cmd_type           cmd,
   output tmsacc_pkg::status_type        status
);
   import tmsacc_pkg::*;

   logic [TPM_W-1:0]  tpm_ff;
   logic [MS_W-1:0]   millis_ff;
   logic [MS_W-1:0]   residue_ff;
   logic [TICK_W-1:0] rem_ff;
   logic [TICK_W-1:0] rem_in;
   logic [TICK_W-1:0] quo_ff;
   logic [TICK_W-1:0] quo_in;
   logic [CNT_W-1:0]  cnt_ff;
   logic              rsp_valid_ff;
   logic [MS_W-1:0]   rsp_millis_ff;
   logic [MS_W-1:0]   rsp_left_ff;

   logic [TICK_W-1:0] divisor;
   logic [TICK_W-1:0] trial;
   logic              fits;
   logic              wrap_hit;

   assign csr_ready = 1'b1;
   assign divisor   = {1'b0, tpm_ff};

   // Hold the divisor register
   always_ff @(posedge clock) begin
      if (reset) begin
         tpm_ff <= TPM_RESET;
      end else if (csr_valid) begin
         tpm_ff <= csr_ticks_per_milli;
      end
   end

   // Restoring divide: one quotient bit per step
   always_comb begin
      trial  = {rem_ff[TICK_W-2:0], quo_ff[TICK_W-1]};
      fits   = (trial >= divisor);
      rem_in = fits ? (trial - divisor) : trial;
      quo_in = {quo_ff[TICK_W-2:0], fits};
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         rem_ff <= '0;
         quo_ff <= req_elapsed_ticks;
         cnt_ff <= '0;
      end else if (cmd.step) begin
         rem_ff <= rem_in;
         quo_ff <= quo_in;
         cnt_ff <= cnt_ff + CNT_W'(1);
      end
   end

   assign wrap_hit = (residue_ff >= divisor);

   // Accumulate quotient and remainder, then fold one millisecond back
   always_ff @(posedge clock) begin
      if (reset) begin
         millis_ff  <= '0;
         residue_ff <= '0;
      end else if (cmd.accum) begin
         millis_ff  <= millis_ff + quo_ff;
         residue_ff <= residue_ff + rem_ff;
      end else if (cmd.wrap && wrap_hit) begin
         millis_ff  <= millis_ff + MS_W'(1);
         residue_ff <= residue_ff - divisor;
      end
   end

   // Hold the result beat until the receiver takes it
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.publish) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.publish) begin
         rsp_millis_ff <= millis_ff;
         rsp_left_ff   <= residue_ff;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_millis_now     = rsp_millis_ff;
   assign rsp_leftover_ticks = rsp_left_ff;

   assign status.div_zero = (tpm_ff == '0);
   assign status.div_last = (cnt_ff == CNT_LAST);
   assign status.out_busy = rsp_valid_ff && !rsp_ready;

endmodule
